>>> sv/bag_pkg.sv
// Package for the broadcast address generator: shared widths, defaults and
// the link types that run between neighboring axis cells. No dependencies.
package bag_pkg;

   localparam int MAX_DIMS_DEFAULT   = 4;
   localparam int INDEX_BITS_DEFAULT = 31;
   localparam int DIM_BITS           = 16;

   typedef logic [DIM_BITS-1:0] dim_type;

   localparam dim_type DIM_ZERO = dim_type'(0);
   localparam dim_type DIM_ONE  = dim_type'(1);

   // shape check, handed from inner to outer cell
   typedef struct packed {
      logic err;   // zero size or incompatible source axis so far
      logic over;  // running target element count too large
   } chk_link_type;

   // odometer step, handed from inner to outer cell
   typedef struct packed {
      logic carry;    // this axis is asked to advance
      logic last;     // every inner axis sits at its top after this step
      logic all_top;  // every inner axis sits at its top now
   } odo_link_type;

endpackage

>>> sv/bag_if.sv
// Request and response channel interfaces of the broadcast address generator.
// Depends on bag_pkg for the default index width.
interface bag_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface bag_rsp_if #(parameter int INDEX_BITS = bag_pkg::INDEX_BITS_DEFAULT);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] out_index;
   logic [INDEX_BITS-1:0] src_index;
   logic                  last;
   logic                  shape_error;

   modport source (output valid, output out_index, output src_index, output last,
                   output shape_error, input ready);
   modport sink (input valid, input out_index, input src_index, input last,
                 input shape_error, output ready);
endinterface

>>> sv/broadcast_address_generator_top.sv
// Broadcast address generator: one (target, source) index pair per accepted
// request that restarts or advances a pass, into a registered output buffer;
// one request per cycle while not settling and the buffer is not full. After
// reset and after every register write, requests stall while strides and the shape check ripple through the axis cells.
// Reset is synchronous, active high; registers return to 1, no pass running.
// Depends on bag_pkg, bag_if, bag_axis_cell and bag_out_buf.
module broadcast_address_generator_top #(
   parameter int MAX_DIMS   = bag_pkg::MAX_DIMS_DEFAULT,
   parameter int INDEX_BITS = bag_pkg::INDEX_BITS_DEFAULT,
   parameter int CSR_IDX_BITS = $clog2(2 * MAX_DIMS) + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   bag_req_if.sink                  req,
   bag_rsp_if.source                rsp,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  bag_pkg::dim_type         csr_wdata
);
   import bag_pkg::*;

   localparam int SETTLE_BITS = $clog2(MAX_DIMS + 1);

   dim_type tgt_dim_ff [MAX_DIMS];
   dim_type src_dim_ff [MAX_DIMS];

   logic [SETTLE_BITS-1:0] settle_ff;
   logic                   active_ff;
   logic [INDEX_BITS-1:0]  out_pos_ff, src_pos_ff;

   logic [INDEX_BITS-1:0] run_w    [MAX_DIMS+1];
   logic [INDEX_BITS-1:0] rewind_w [MAX_DIMS+1];
   logic [INDEX_BITS-1:0] total_w  [MAX_DIMS+1];
   logic [INDEX_BITS-1:0] delta_w  [MAX_DIMS+1];
   chk_link_type          chk_w    [MAX_DIMS+1];
   odo_link_type          odo_w    [MAX_DIMS+1];

   logic csr_hit, accept, bad, done, advance, load, push, full;
   logic [INDEX_BITS-1:0] push_out, push_src;
   logic push_last, push_err;

   assign csr_hit = csr_we & (csr_index < CSR_IDX_BITS'(2 * MAX_DIMS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            tgt_dim_ff[i] <= DIM_ONE;
            src_dim_ff[i] <= DIM_ONE;
         end
      end else if (csr_we) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (csr_index == CSR_IDX_BITS'(i)) begin
               tgt_dim_ff[i] <= csr_wdata;
            end
            if (csr_index == CSR_IDX_BITS'(MAX_DIMS + i)) begin
               src_dim_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // innermost cell sees the empty-shape boundary values
   assign run_w[MAX_DIMS]    = INDEX_BITS'(1);
   assign rewind_w[MAX_DIMS] = '0;
   assign total_w[MAX_DIMS]  = INDEX_BITS'(1);
   assign chk_w[MAX_DIMS]    = '{err: 1'b0, over: 1'b0};
   assign odo_w[MAX_DIMS]    = '{carry: advance, last: 1'b1, all_top: 1'b1};
   assign delta_w[MAX_DIMS]  = '0;

   for (genvar g = 0; g < MAX_DIMS; g++) begin : g_axis
      bag_axis_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tgt_dim    (tgt_dim_ff[g]),
         .src_dim    (src_dim_ff[g]),
         .run_in     (run_w[g+1]),
         .rewind_in  (rewind_w[g+1]),
         .total_in   (total_w[g+1]),
         .chk_in     (chk_w[g+1]),
         .run_out    (run_w[g]),
         .rewind_out (rewind_w[g]),
         .total_out  (total_w[g]),
         .chk_out    (chk_w[g]),
         .load       (load),
         .odo_in     (odo_w[g+1]),
         .delta_in   (delta_w[g+1]),
         .odo_out    (odo_w[g]),
         .delta_out  (delta_w[g])
      );
   end

   assign req.ready = (settle_ff == '0) & ~full;
   assign accept    = req.valid & req.ready;
   assign bad       = chk_w[0].err | chk_w[0].over;
   assign done      = ~active_ff | odo_w[0].all_top;
   assign advance   = accept & ~req.restart & ~done;
   assign load      = accept & req.restart & ~bad;
   assign push      = accept & (req.restart | ~done);

   always_comb begin
      if (req.restart) begin
         push_out  = '0;
         push_src  = '0;
         push_last = bad | odo_w[0].last;
         push_err  = bad;
      end else begin
         push_out  = out_pos_ff + INDEX_BITS'(1);
         push_src  = src_pos_ff + delta_w[0];
         push_last = odo_w[0].last;
         push_err  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_BITS'(MAX_DIMS);
         active_ff <= 1'b0;
      end else begin
         if (csr_hit) begin
            settle_ff <= SETTLE_BITS'(MAX_DIMS);
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - SETTLE_BITS'(1);
         end
         if (csr_hit) begin
            active_ff <= 1'b0;
         end else if (accept && req.restart) begin
            active_ff <= ~bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load || advance) begin
         out_pos_ff <= push_out;
         src_pos_ff <= push_src;
      end
   end

   bag_out_buf #(.INDEX_BITS(INDEX_BITS)) u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .push_out_index   (push_out),
      .push_src_index   (push_src),
      .push_last        (push_last),
      .push_shape_error (push_err),
      .full             (full),
      .rsp              (rsp)
   );

endmodule

>>> sv/bag_axis_cell.sv
// One axis of the broadcast walk: holds the axis counter, its source stride
// and jump, and folds its dimension into the shape check. Uses bag_pkg.
module bag_axis_cell #(
   parameter int INDEX_BITS = bag_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bag_pkg::dim_type        tgt_dim,
   input  bag_pkg::dim_type        src_dim,
   // shape chain, registered
   input  logic [INDEX_BITS-1:0]   run_in,
   input  logic [INDEX_BITS-1:0]   rewind_in,
   input  logic [INDEX_BITS-1:0]   total_in,
   input  bag_pkg::chk_link_type   chk_in,
   output logic [INDEX_BITS-1:0]   run_out,
   output logic [INDEX_BITS-1:0]   rewind_out,
   output logic [INDEX_BITS-1:0]   total_out,
   output bag_pkg::chk_link_type   chk_out,
   // odometer chain
   input  logic                    load,
   input  bag_pkg::odo_link_type   odo_in,
   input  logic [INDEX_BITS-1:0]   delta_in,
   output bag_pkg::odo_link_type   odo_out,
   output logic [INDEX_BITS-1:0]   delta_out
);
   import bag_pkg::*;

   localparam int PROD_BITS = INDEX_BITS + DIM_BITS;
   localparam int CNT_BITS  = DIM_BITS + 1;

   logic [INDEX_BITS-1:0] run_ff, rewind_ff, total_ff, jump_ff;
   chk_link_type          chk_ff;
   dim_type               count_ff, count_in;
   logic                  top_ff, top_in;

   logic [INDEX_BITS-1:0] stride;
   logic [PROD_BITS-1:0]  run_prod, span_prod, total_prod;
   logic [CNT_BITS-1:0]   count_plus;
   logic                  inc, wrap;

   // stride is the product of inner source sizes, or zero on a broadcast axis
   always_comb begin
      stride     = (src_dim == DIM_ONE) ? '0 : run_in;
      run_prod   = PROD_BITS'(run_in) * PROD_BITS'(src_dim);
      span_prod  = PROD_BITS'(tgt_dim - DIM_ONE) * PROD_BITS'(stride);
      total_prod = PROD_BITS'(total_in) * PROD_BITS'(tgt_dim);
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_prod[INDEX_BITS-1:0];
      rewind_ff   <= rewind_in + span_prod[INDEX_BITS-1:0];
      total_ff    <= total_prod[INDEX_BITS-1:0];
      // moving up this axis while all inner axes roll back to zero
      jump_ff     <= stride - rewind_in;
      chk_ff.err  <= chk_in.err | (tgt_dim == DIM_ZERO) | (src_dim == DIM_ZERO)
                     | ((src_dim != DIM_ONE) && (src_dim != tgt_dim));
      chk_ff.over <= chk_in.over | (|total_prod[PROD_BITS-1:INDEX_BITS]);
   end

   assign run_out    = run_ff;
   assign rewind_out = rewind_ff;
   assign total_out  = total_ff;
   assign chk_out    = chk_ff;

   always_comb begin
      inc        = odo_in.carry & ~top_ff;
      wrap       = odo_in.carry & top_ff;
      count_plus = {1'b0, count_ff} + CNT_BITS'(1);
      count_in   = count_ff;
      top_in     = top_ff;
      if (load || wrap) begin
         count_in = DIM_ZERO;
         top_in   = (tgt_dim <= DIM_ONE);
      end else if (inc) begin
         count_in = count_plus[DIM_BITS-1:0];
         top_in   = ((count_plus + CNT_BITS'(1)) >= {1'b0, tgt_dim});
      end
      odo_out.carry   = wrap;
      odo_out.all_top = odo_in.all_top & top_ff;
      odo_out.last    = odo_in.last & top_in;
      delta_out       = inc ? jump_ff : delta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DIM_ZERO;
         top_ff   <= 1'b1;
      end else begin
         count_ff <= count_in;
         top_ff   <= top_in;
      end
   end

endmodule

>>> sv/bag_out_buf.sv
// Two-entry output buffer (output register plus skid) for response items.
// Uses bag_pkg and the bag_rsp_if interface.
module bag_out_buf #(
   parameter int INDEX_BITS = bag_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [INDEX_BITS-1:0] push_out_index,
   input  logic [INDEX_BITS-1:0] push_src_index,
   input  logic                  push_last,
   input  logic                  push_shape_error,
   output logic                  full,
   bag_rsp_if.source             rsp
);
   import bag_pkg::*;

   logic                  main_valid_ff, skid_valid_ff;
   logic [INDEX_BITS-1:0] main_out_ff, main_src_ff, skid_out_ff, skid_src_ff;
   logic                  main_last_ff, main_err_ff, skid_last_ff, skid_err_ff;
   logic                  pop;

   assign pop  = main_valid_ff & rsp.ready;
   assign full = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_out_ff  <= skid_out_ff;
            main_src_ff  <= skid_src_ff;
            main_last_ff <= skid_last_ff;
            main_err_ff  <= skid_err_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_out_ff  <= push_out_index;
            main_src_ff  <= push_src_index;
            main_last_ff <= push_last;
            main_err_ff  <= push_shape_error;
         end else begin
            skid_out_ff  <= push_out_index;
            skid_src_ff  <= push_src_index;
            skid_last_ff <= push_last;
            skid_err_ff  <= push_shape_error;
         end
      end
   end

   assign rsp.valid       = main_valid_ff;
   assign rsp.out_index   = main_out_ff;
   assign rsp.src_index   = main_src_ff;
   assign rsp.last        = main_last_ff;
   assign rsp.shape_error = main_err_ff;

endmodule
